>>> hdl/brfifo_pkg.sv
package brfifo_pkg;

  // storage depth and derived widths
  localparam int DEPTH     = 64;
  localparam int AW        = $clog2(DEPTH);
  localparam int DATA_W    = 8;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0]  CAP_RESET   = CNT_W'(DEPTH);
  localparam logic [DATA_W-1:0] DELIM_RESET = DATA_W'(10);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY  = 1'b0,
    REG_DELIMITER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic              has_byte;
    logic              run_last;
    logic              write_accepted;
    logic [CNT_W-1:0]  fill_level;
  } res_t;

  // capacity clamped to 1..DEPTH
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    if (cap == '0) begin
      r = CNT_W'(1);
    end else if (cap > CNT_W'(DEPTH)) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = cap;
    end
    return r;
  endfunction

  // pointer step with wrap at the clamped capacity
  function automatic logic [AW-1:0] adv_pos(input logic [AW-1:0] pos,
                                            input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] n;
    logic [AW-1:0]  r;
    n = (CNT_W + 1)'(pos) + (CNT_W + 1)'(1);
    if (n >= (CNT_W + 1)'(cap)) begin
      r = '0;
    end else begin
      r = n[AW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/brfifo_ram.sv
module brfifo_ram #(
  parameter int DATA_WIDTH = 8,
  parameter int RAM_DEPTH  = 64
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(RAM_DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]        wdata,
  input  logic                         re,
  input  logic [$clog2(RAM_DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]        rdata
);

  logic [DATA_WIDTH-1:0] mem_r [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> hdl/brfifo_front.sv
module brfifo_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [brfifo_pkg::DATA_W-1:0] in_data_byte,
  input  logic                         in_msg_last,
  output logic                         cmd_valid,
  output brfifo_pkg::cmd_t             cmd,
  input  logic                         cmd_pop
);
  import brfifo_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  cmd_t           in_cmd;

  assign in_stall  = (cnt_r == QCW'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // classify the incoming item
  always_comb begin
    in_cmd.op   = in_func ? OP_READ : OP_WRITE;
    in_cmd.data = in_data_byte;
    in_cmd.last = in_msg_last;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

>>> hdl/brfifo_back.sv
module brfifo_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [brfifo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brfifo_pkg::CFG_W-1:0]    cfg_data,
  input  logic                            cmd_valid,
  input  brfifo_pkg::cmd_t                cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output brfifo_pkg::res_t                out_res
);
  import brfifo_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RD_DATA
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic [AW-1:0]     rpos_r, rpos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [DATA_W-1:0] delim_r;
  logic              out_valid_r;
  res_t              out_res_r;
  res_t              res_nxt;
  logic              emit;
  logic              can_emit;
  logic              wr_ok;
  logic              stop;
  logic [CNT_W-1:0]  cap_eff;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign cap_eff   = eff_cap(cap_r);
  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  brfifo_ram #(
    .DATA_WIDTH(DATA_W),
    .RAM_DEPTH (DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wpos_r),
    .wdata(cmd.data),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    wpos_nxt  = wpos_r;
    rpos_nxt  = rpos_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    emit      = 1'b0;
    res_nxt   = out_res_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rpos_r;
    wr_ok     = 1'b0;
    stop      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_WRITE) begin
            wr_ok = !drop_r && (count_r < cap_eff) && (cmd.data != '0);
            if (wr_ok) begin
              ram_we    = 1'b1;
              wpos_nxt  = adv_pos(wpos_r, cap_eff);
              count_nxt = count_r + CNT_W'(1);
            end
            drop_nxt               = !wr_ok && !cmd.last;
            emit                   = 1'b1;
            res_nxt.read_byte      = '0;
            res_nxt.has_byte       = 1'b0;
            res_nxt.run_last       = 1'b1;
            res_nxt.write_accepted = wr_ok;
            res_nxt.fill_level     = count_nxt;
          end else if (count_r == '0) begin
            emit                   = 1'b1;
            res_nxt.read_byte      = '0;
            res_nxt.has_byte       = 1'b0;
            res_nxt.run_last       = 1'b1;
            res_nxt.write_accepted = 1'b0;
            res_nxt.fill_level     = '0;
          end else begin
            // fetch the first byte of the run
            ram_re    = 1'b1;
            ram_raddr = rpos_r;
            state_nxt = S_RD_DATA;
          end
        end
      end
      S_RD_DATA: begin
        if (can_emit) begin
          rpos_nxt               = adv_pos(rpos_r, cap_eff);
          count_nxt              = count_r - CNT_W'(1);
          stop                   = (ram_rdata == delim_r) || (count_r == CNT_W'(1));
          emit                   = 1'b1;
          res_nxt.read_byte      = ram_rdata;
          res_nxt.has_byte       = 1'b1;
          res_nxt.run_last       = stop;
          res_nxt.write_accepted = 1'b0;
          res_nxt.fill_level     = count_nxt;
          if (stop) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rpos_nxt;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpos_r      <= '0;
      rpos_r      <= '0;
      count_r     <= '0;
      drop_r      <= 1'b0;
      cap_r       <= CAP_RESET;
      delim_r     <= DELIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wpos_r  <= wpos_nxt;
      rpos_r  <= rpos_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CAPACITY:  cap_r   <= cfg_data[CNT_W-1:0];
          REG_DELIMITER: delim_r <= cfg_data[DATA_W-1:0];
          default: ;
        endcase
      end
    end
    if (emit) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

>>> hdl/byte_ring_fifo_line_read.sv
// circular byte fifo with message-wise writes and delimiter-terminated reads
//
// input channel (in_valid / in_stall): one command per transfer. in_func 0
// stores in_data_byte; in_msg_last marks the last byte of a message. a zero
// byte, a full fifo or an earlier refusal in the message drops the rest of
// the message up to its last byte. in_func 1 drains bytes in order until the
// delimiter byte has gone out or the fifo runs empty.
// output channel (out_valid / out_stall): a write gives one transfer with
// out_write_accepted; a read gives one transfer per byte, out_run_last on
// the final one; a read of an empty fifo gives one transfer without a byte.
// config port: cfg_we with cfg_index 0 sets the capacity (1..64, 0 acts as
// 1), index 1 the delimiter; write only while the block is idle.
// timing: the engine handles a write in its idle state; a read fetches the
// first byte from the ram, then gives one byte per cycle while out_stall is
// low, set by the single registered ram read port. a write result passes the
// command queue and output register, a read byte also the ram read register.
// a two-entry command queue sits ahead of the engine.
// reset clears pointers, count and drop state; capacity 64, delimiter 10.
// out_stall holds a valid output register and then freezes the engine in place.
module byte_ring_fifo_line_read (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [brfifo_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                             in_msg_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [brfifo_pkg::DATA_W-1:0]    out_read_byte,
  output logic                             out_has_byte,
  output logic                             out_run_last,
  output logic                             out_write_accepted,
  output logic [brfifo_pkg::CNT_W-1:0]     out_fill_level,
  input  logic                             cfg_we,
  input  logic [brfifo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brfifo_pkg::CFG_W-1:0]     cfg_data
);
  import brfifo_pkg::*;

  // queue between front and engine
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t out_res;

  brfifo_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_data_byte(in_data_byte),
    .in_msg_last (in_msg_last),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // execution engine with byte store and output register
  brfifo_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_read_byte      = out_res.read_byte;
  assign out_has_byte       = out_res.has_byte;
  assign out_run_last       = out_res.run_last;
  assign out_write_accepted = out_res.write_accepted;
  assign out_fill_level     = out_res.fill_level;

endmodule

>>> hdl/brfifo_chk.sv
module brfifo_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [brfifo_pkg::DATA_W-1:0] out_read_byte,
  input logic                          out_has_byte,
  input logic                          out_run_last,
  input logic                          out_write_accepted,
  input logic [brfifo_pkg::CNT_W-1:0]  out_fill_level
);
  import brfifo_pkg::*;

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a stored write is a single transfer with no byte
  a_write_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_accepted) |-> (out_run_last && !out_has_byte))
    else $error("accepted write result malformed");

  // a transfer without a byte carries a zero byte
  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> (out_read_byte == '0))
    else $error("nonzero byte without has_byte");

  // a drained byte that empties the fifo ends the run
  a_empty_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_byte && (out_fill_level == '0)) |-> out_run_last)
    else $error("run continues past empty fifo");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_byte)
      && $stable(out_fill_level) && $stable(out_run_last)))
    else $error("stalled output changed");

endmodule

bind byte_ring_fifo_line_read brfifo_chk u_brfifo_chk (.*);

>>> tb/brfifo_line_check.sv
`timescale 1ns / 1ps

module brfifo_line_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_func,
  input  logic [brfifo_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                             in_msg_last,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [brfifo_pkg::DATA_W-1:0]    out_read_byte,
  input  logic                             out_has_byte,
  input  logic                             out_run_last,
  input  logic                             out_write_accepted,
  input  logic [brfifo_pkg::CNT_W-1:0]     out_fill_level,
  input  logic                             cfg_we,
  input  logic [brfifo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brfifo_pkg::CFG_W-1:0]     cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               held
);
  import brfifo_pkg::*;

  // shadow copy of the fifo contents and control state
  logic [DATA_W-1:0] ring [DEPTH];
  logic [AW-1:0]     put_at;
  logic [AW-1:0]     take_at;
  logic [CNT_W-1:0]  held_bytes;
  logic              skip_msg;
  logic [CNT_W-1:0]  cap_reg;
  logic [DATA_W-1:0] delim_reg;

  res_t due_results[$];
  int   miscount = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
  end

  function automatic int cap_in_use();
    int c;
    c = int'(cap_reg);
    if (c == 0) begin
      c = 1;
    end else if (c > DEPTH) begin
      c = DEPTH;
    end
    return c;
  endfunction

  function automatic logic [AW-1:0] step_pos(input logic [AW-1:0] pos);
    int nx;
    nx = int'(pos) + 1;
    return (nx >= cap_in_use()) ? '0 : AW'(nx);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    miscount++;
  endtask

  // expected transfers for one accepted command
  task automatic fifo_exec_cmd(input op_t op, input logic [DATA_W-1:0] d,
                               input logic l);
    res_t              r;
    logic              ok;
    logic              stop;
    logic [DATA_W-1:0] ch;
    int                n;
    r = '0;
    if (op == OP_WRITE) begin
      ok = !skip_msg && (int'(held_bytes) < cap_in_use()) && (d != '0);
      if (ok) begin
        ring[put_at] = d;
        put_at = step_pos(put_at);
        held_bytes = held_bytes + CNT_W'(1);
      end
      skip_msg = !ok && !l;
      r.run_last       = 1'b1;
      r.write_accepted = ok;
      r.fill_level     = held_bytes;
      due_results.push_back(r);
    end else if (held_bytes == '0) begin
      r.run_last = 1'b1;
      due_results.push_back(r);
    end else begin
      n    = 0;
      stop = 1'b0;
      while (!stop) begin
        ch = ring[take_at];
        take_at = step_pos(take_at);
        held_bytes = held_bytes - CNT_W'(1);
        stop = (ch == delim_reg) || (held_bytes == '0) || (n == DEPTH - 1);
        r.read_byte      = ch;
        r.has_byte       = 1'b1;
        r.run_last       = stop;
        r.write_accepted = 1'b0;
        r.fill_level     = held_bytes;
        due_results.push_back(r);
        n++;
      end
    end
  endtask

  task automatic check_result();
    res_t want;
    if (due_results.size() == 0) begin
      flag_mismatch("transfer with nothing due", 1, 0);
    end else begin
      want = due_results.pop_front();
      if (out_read_byte !== want.read_byte)
        flag_mismatch("read_byte", out_read_byte, want.read_byte);
      if (out_has_byte !== want.has_byte)
        flag_mismatch("has_byte", out_has_byte, want.has_byte);
      if (out_run_last !== want.run_last)
        flag_mismatch("run_last", out_run_last, want.run_last);
      if (out_write_accepted !== want.write_accepted)
        flag_mismatch("write_accepted", out_write_accepted, want.write_accepted);
      if (out_fill_level !== want.fill_level)
        flag_mismatch("fill_level", out_fill_level, want.fill_level);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      put_at     = '0;
      take_at    = '0;
      held_bytes = '0;
      skip_msg   = 1'b0;
      cap_reg    = CAP_RESET;
      delim_reg  = DELIM_RESET;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == REG_CAPACITY) begin
          cap_reg = cfg_data[CNT_W-1:0];
        end else begin
          delim_reg = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        fifo_exec_cmd(op_t'(in_func), in_data_byte, in_msg_last);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
    end
    pending    <= due_results.size();
    held       <= int'(held_bytes);
    fail_count <= miscount;
  end

endmodule

>>> tb/byte_ring_fifo_line_read_test.sv
`timescale 1ns / 1ps

module byte_ring_fifo_line_read_test;
  import brfifo_pkg::*;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic              in_valid     = 1'b0;
  logic              in_func      = 1'b0;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic              in_msg_last  = 1'b0;
  logic              out_stall    = 1'b0;
  logic              cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data     = '0;

  // block outputs
  logic              in_stall;
  logic              out_valid;
  logic [DATA_W-1:0] out_read_byte;
  logic              out_has_byte;
  logic              out_run_last;
  logic              out_write_accepted;
  logic [CNT_W-1:0]  out_fill_level;

  // status handed up by the checker
  int fail_count;
  int pending;
  int held;

  // stimulus bookkeeping
  int                sent_count = 0;
  int                burst_left = 0;
  logic [DATA_W-1:0] cur_delim  = DELIM_RESET;

  byte_ring_fifo_line_read dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .in_msg_last        (in_msg_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_byte      (out_read_byte),
    .out_has_byte       (out_has_byte),
    .out_run_last       (out_run_last),
    .out_write_accepted (out_write_accepted),
    .out_fill_level     (out_fill_level),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  brfifo_line_check check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .in_msg_last        (in_msg_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_byte      (out_read_byte),
    .out_has_byte       (out_has_byte),
    .out_run_last       (out_run_last),
    .out_write_accepted (out_write_accepted),
    .out_fill_level     (out_fill_level),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .held               (held)
  );

  // receiver back-pressure: a mode is picked for a stretch of cycles,
  // from no stalls at all through heavy random stalls to a periodic pattern
  int stall_left = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // one command transfer; the sender works in bursts with random gaps,
  // valid stays high across the items of a burst
  task automatic push_cmd(input op_t op, input logic [DATA_W-1:0] d, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_func      <= op;
    in_data_byte <= d;
    in_msg_last  <= l;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic push_read();
    push_cmd(OP_READ, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // stop sending and wait until every due transfer has come out
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write both registers on back-to-back cycles, only while idle
  task automatic set_regs(input logic [CNT_W-1:0] cap, input logic [DATA_W-1:0] delim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= CFG_W'(cap);
    @(posedge clk);
    cfg_index <= REG_DELIMITER;
    cfg_data  <= delim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_delim = delim;
  endtask

  // read until the fifo is empty
  task automatic drain_all();
    while (held != 0) begin
      push_read();
      settle();
    end
  endtask

  // one well-formed message: mostly nonzero bytes, sometimes the delimiter,
  // a rare zero byte that drops the rest, reads sprinkled in between
  task automatic push_message(input int len);
    logic [DATA_W-1:0] b;
    int                r;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) push_read();
      b = DATA_W'($urandom_range(1, 255));
      r = $urandom_range(0, 15);
      if (r == 0) begin
        b = '0;
      end else if (r < 3) begin
        b = cur_delim;
      end
      if (i == len - 1 && $urandom_range(0, 1) == 1) b = cur_delim;
      push_cmd(OP_WRITE, b, i == len - 1);
    end
  endtask

  initial begin
    int base;
    int phase;
    int start;
    int pick;
    logic [CNT_W-1:0]  cap;
    logic [DATA_W-1:0] delim;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(CAP_RESET, DELIM_RESET);

    // fill every entry once at full capacity so that later capacity
    // changes can never expose an entry that was never written
    for (int i = 0; i < DEPTH; i++) begin
      push_cmd(OP_WRITE, DATA_W'($urandom_range(1, 255)), 1'b1);
    end
    // full fifo refuses a byte
    push_cmd(OP_WRITE, 8'h5a, 1'b1);
    settle();
    drain_all();

    // directed: read on empty, extreme bytes, the delimiter ending a run
    push_read();
    push_cmd(OP_WRITE, 8'h01, 1'b1);
    push_cmd(OP_WRITE, 8'hff, 1'b1);
    push_cmd(OP_WRITE, DELIM_RESET, 1'b1);
    push_cmd(OP_WRITE, 8'h55, 1'b1);
    push_read();
    push_read();
    push_read();
    // zero byte mid-message drops the rest up to its last byte
    push_cmd(OP_WRITE, 8'h41, 1'b0);
    push_cmd(OP_WRITE, 8'h00, 1'b0);
    push_cmd(OP_WRITE, 8'h42, 1'b0);
    push_cmd(OP_WRITE, 8'h43, 1'b1);
    push_cmd(OP_WRITE, 8'h44, 1'b1);
    // zero byte that is itself the last one: no drop state afterward
    push_cmd(OP_WRITE, 8'h00, 1'b1);
    // a read in the middle of a dropped message leaves the drop state alone
    push_cmd(OP_WRITE, 8'h00, 1'b0);
    push_read();
    push_cmd(OP_WRITE, 8'h45, 1'b1);
    push_cmd(OP_WRITE, 8'h46, 1'b1);
    // leave data in the fifo, then shrink the capacity underneath it
    for (int i = 0; i < 5; i++) begin
      push_cmd(OP_WRITE, DATA_W'(8'h30 + i), 1'b1);
    end
    settle();
    set_regs(7'd3, 8'h31);
    // over capacity now: refused without last sets the drop state
    push_cmd(OP_WRITE, 8'h35, 1'b0);
    push_cmd(OP_WRITE, 8'h36, 1'b1);
    push_read();
    push_read();
    push_read();

    // random phases, each under its own register setting; the first few
    // hit the extremes, including a capacity of zero and one above the depth
    base  = sent_count;
    phase = 0;
    while (sent_count - base < 200) begin
      settle();
      if ($urandom_range(0, 2) == 0) drain_all();
      case (phase)
        0: begin cap = 7'd1;   delim = 8'h00; end
        1: begin cap = 7'd64;  delim = 8'hff; end
        2: begin cap = 7'd0;   delim = DATA_W'($urandom_range(0, 255)); end
        3: begin cap = 7'd100; delim = 8'h0a; end
        4: begin cap = 7'd127; delim = DATA_W'($urandom_range(0, 255)); end
        default: begin
          cap   = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(9, 64))
                                               : CNT_W'($urandom_range(1, 8));
          delim = ($urandom_range(0, 1) == 0) ? 8'h0a : 8'($urandom_range(0, 255));
        end
      endcase
      set_regs(cap, delim);
      start = sent_count;
      while (sent_count - start < 30) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          push_message($urandom_range(1, 10));
        end else if (pick < 17) begin
          push_read();
        end else begin
          // noise: loose write with a random last flag
          push_cmd(OP_WRITE, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
      phase++;
    end

    // let every due transfer come out, then a short tail for strays
    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("byte_ring_fifo_line_read regression: pass");
    end else begin
      $display("byte_ring_fifo_line_read regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("byte_ring_fifo_line_read regression: fail");
    $finish;
  end

endmodule

>>> files.f
hdl/brfifo_pkg.sv
hdl/brfifo_ram.sv
hdl/brfifo_front.sv
hdl/brfifo_back.sv
hdl/byte_ring_fifo_line_read.sv
hdl/brfifo_chk.sv
tb/brfifo_line_check.sv
tb/byte_ring_fifo_line_read_test.sv
